FILE: rtl/tclc_pkg.sv
// Shared types, constants and keyword tables of the command line classifier.
package tclc_pkg;

    localparam int LINE_BUFFER_BYTES_DEF = 128;

    // Depth of the token queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_TAIL,
        PH_ARG_WS,
        PH_ARG_SIGN,
        PH_ARG_DIGITS,
        PH_ARG_DONE,
        PH_DEAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_UNKNOWN,
        KIND_STATUS,
        KIND_STOP,
        KIND_INTERVAL
    } t_kind;

    localparam int KW_GET   = 0;
    localparam int KW_STOP  = 1;
    localparam int KW_SET   = 2;
    localparam int KW_COUNT = 3;

    localparam logic [KW_COUNT-1:0] CAND_ALL = '1;

    // Keyword text, right-justified; padded so any 4-bit offset selects in range.
    localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
        128'("GET_STATUS"),
        128'("STOP"),
        128'("SET_INTERVAL")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd10, 4'd4, 4'd12};

    localparam logic [31:0] MAG_CAP  = 32'h8000_0000;
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef struct packed {
        logic ws;
        logic digit;
        logic sign;
        logic minus;
    } t_class;

    typedef struct packed {
        logic [7:0] data;
        logic       eol;
        logic       counts;
        t_class     cls;
    } t_token;

    // Character of keyword k at offset idx, counted from the left.
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] idx);
        logic [127:0] txt;
        logic [3:0]   pos;
        txt = KW_TEXT[k];
        pos = KW_LEN[k] - 4'd1 - idx;
        return txt[{pos, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/tclc_if.sv
// Handshake interfaces for the byte input channel and the result channel.
interface tclc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       end_of_line;

    modport source(output valid, output line_byte, output end_of_line, input ready);
    modport sink(input valid, input line_byte, input end_of_line, output ready);
endinterface

interface tclc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command_kind;
    logic signed [31:0] interval_value;

    modport source(output valid, output command_kind, output interval_value, input ready);
    modport sink(input valid, input command_kind, input interval_value, output ready);
endinterface

FILE: rtl/tclc_front.sv
// Front end: accepts bytes, tracks line position and zero termination, classifies each byte.
module tclc_front #(
    parameter int LINE_BUFFER_BYTES = tclc_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tclc_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output tclc_pkg::t_token o_token
);
    import tclc_pkg::*;

    localparam int              PW       = $clog2(LINE_BUFFER_BYTES);
    localparam logic [PW-1:0]   POS_LAST = PW'(LINE_BUFFER_BYTES - 1);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_term, n_term;
    logic          accept;
    logic          live;
    logic [7:0]    b;

    assign b          = i_in.line_byte;
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign live       = !r_term && (r_pos < POS_LAST);
    assign o_push     = accept;

    always_comb begin
        o_token.data      = b;
        o_token.eol       = i_in.end_of_line;
        o_token.counts    = live && (b != 8'd0);
        o_token.cls.ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        o_token.cls.digit = (b >= CH_ZERO) && (b <= CH_NINE);
        o_token.cls.sign  = (b == CH_PLUS) || (b == CH_MINUS);
        o_token.cls.minus = (b == CH_MINUS);
    end

    always_comb begin
        n_pos  = r_pos;
        n_term = r_term;
        if (accept) begin
            if (i_in.end_of_line) begin
                n_pos  = '0;
                n_term = 1'b0;
            end else if (live) begin
                n_pos = r_pos + PW'(1);
                if (b == 8'd0) begin
                    n_term = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_term <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_term <= n_term;
        end
    end

endmodule

FILE: rtl/tclc_queue.sv
// Short token queue that decouples the front end from the parser.
module tclc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tclc_pkg::t_token i_token,
    input  logic             i_pop,
    output tclc_pkg::t_token o_token,
    output logic             o_valid,
    output logic             o_full
);
    import tclc_pkg::*;

    t_token              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_CW-1:0] r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_token = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QUEUE_CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/tclc_back.sv
// Back end: keyword match and number parse per token, result register at the line end.
module tclc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tclc_pkg::t_token i_token,
    output logic             o_pop,
    tclc_out_if.source       o_out
);
    import tclc_pkg::*;

    t_phase              r_phase, n_phase;
    logic [KW_COUNT-1:0] r_cand, n_cand;
    logic [3:0]          r_off, n_off;
    logic                r_neg, n_neg;
    logic [31:0]         r_acc, n_acc;
    logic                r_seen, n_seen;

    logic                r_out_valid, n_out_valid;
    t_kind               r_kind, n_kind;
    logic [31:0]         r_value, n_value;

    logic                slot_free;
    logic                take;
    logic [KW_COUNT-1:0] cin, keep;
    logic [3:0]          oin, key_off;
    t_phase              key_phase;
    logic [35:0]         mul;
    logic [31:0]         dig_acc;
    t_kind               res_kind;
    logic [31:0]         res_value;

    assign slot_free = !r_out_valid || o_out.ready;
    assign o_pop     = i_valid && (!i_token.eol || slot_free);
    assign take      = o_pop && i_token.counts;

    assign o_out.valid          = r_out_valid;
    assign o_out.command_kind   = r_kind;
    assign o_out.interval_value = r_value;

    // Keyword matcher; the first non-blank byte starts from all candidates.
    always_comb begin
        cin = (r_phase == PH_LEAD) ? CAND_ALL : r_cand;
        oin = (r_phase == PH_LEAD) ? 4'd0 : r_off;
        for (int k = 0; k < KW_COUNT; k++) begin
            keep[k] = cin[k] && (oin < KW_LEN[k]) && (kw_char(k, oin) == i_token.data);
        end
        key_off = oin + 4'd1;
        if (keep == '0) begin
            key_phase = PH_DEAD;
        end else if (keep[KW_SET] && (key_off == KW_LEN[KW_SET])) begin
            key_phase = PH_ARG_WS;
        end else if (keep[KW_GET] && (key_off == KW_LEN[KW_GET])) begin
            key_phase = PH_TAIL;
        end else if (keep[KW_STOP] && (key_off == KW_LEN[KW_STOP])) begin
            key_phase = PH_TAIL;
        end else begin
            key_phase = PH_KEY;
        end
    end

    // Decimal accumulate: times ten as two shifts, magnitude capped at 2^31.
    always_comb begin
        mul     = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {32'd0, i_token.data[3:0]};
        dig_acc = (mul > {4'd0, MAG_CAP}) ? MAG_CAP : mul[31:0];
    end

    always_comb begin
        n_phase = r_phase;
        n_cand  = r_cand;
        n_off   = r_off;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_seen  = r_seen;
        if (take) begin
            unique case (r_phase)
                PH_LEAD, PH_KEY: begin
                    if (r_phase == PH_KEY || !i_token.cls.ws) begin
                        n_cand  = keep;
                        n_off   = key_off;
                        n_phase = key_phase;
                    end
                end
                PH_TAIL: begin
                    if (!i_token.cls.ws) begin
                        n_phase = PH_DEAD;
                    end
                end
                PH_ARG_WS: begin
                    if (!i_token.cls.ws) begin
                        if (i_token.cls.sign) begin
                            n_neg   = i_token.cls.minus;
                            n_phase = PH_ARG_SIGN;
                        end else if (i_token.cls.digit) begin
                            n_acc   = dig_acc;
                            n_seen  = 1'b1;
                            n_phase = PH_ARG_DIGITS;
                        end else begin
                            n_phase = PH_ARG_DONE;
                        end
                    end
                end
                PH_ARG_SIGN, PH_ARG_DIGITS: begin
                    if (i_token.cls.digit) begin
                        n_acc   = dig_acc;
                        n_seen  = 1'b1;
                        n_phase = PH_ARG_DIGITS;
                    end else begin
                        n_phase = PH_ARG_DONE;
                    end
                end
                PH_ARG_DONE, PH_DEAD: begin
                end
                default: begin
                end
            endcase
        end

        // Classification from the state after this byte.
        res_kind  = KIND_UNKNOWN;
        res_value = 32'd0;
        unique case (n_phase)
            PH_TAIL: begin
                res_kind = n_cand[KW_GET] ? KIND_STATUS : KIND_STOP;
            end
            PH_ARG_WS, PH_ARG_SIGN, PH_ARG_DIGITS, PH_ARG_DONE: begin
                res_kind = KIND_INTERVAL;
                if (n_seen) begin
                    if (n_neg) begin
                        res_value = 32'd0 - n_acc;
                    end else begin
                        res_value = (n_acc >= MAG_CAP) ? POS_MAX : n_acc;
                    end
                end
            end
            default: begin
            end
        endcase

        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_value     = r_value;
        if (o_pop && i_token.eol) begin
            n_out_valid = 1'b1;
            n_kind      = res_kind;
            n_value     = res_value;
            n_phase     = PH_LEAD;
            n_cand      = CAND_ALL;
            n_off       = 4'd0;
            n_neg       = 1'b0;
            n_acc       = 32'd0;
            n_seen      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_cand      <= CAND_ALL;
            r_off       <= 4'd0;
            r_neg       <= 1'b0;
            r_acc       <= 32'd0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cand      <= n_cand;
            r_off       <= n_off;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/text_command_line_classifier.sv
// The last byte of a line enters the token queue; its result is registered in the output register once popped.
// Throughput: one byte per cycle while the queue is not full, limited by the single-byte parser step in the back end.
// The four-entry token queue lets the input run while a finished result waits to be taken.
// At most one result per line; it is held in an output register until taken.
// Reset (synchronous, active low) empties the queue and returns all line state to its start.
module text_command_line_classifier #(
    parameter int LINE_BUFFER_BYTES = tclc_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tclc_in_if.sink    i_in,
    tclc_out_if.source o_out
);
    import tclc_pkg::*;

    t_token push_token, pop_token;
    logic   push, pop, q_valid, q_full;

    tclc_front #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_token (push_token)
    );

    tclc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .i_pop   (pop),
        .o_token (pop_token),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    tclc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_token (pop_token),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
